// File: hdl/midi_note_region_mapper_macros.svh
// Assertion macros for the note region mapper.
`ifndef MIDI_NOTE_REGION_MAPPER_MACROS_SVH
`define MIDI_NOTE_REGION_MAPPER_MACROS_SVH

// same-cycle implication
`define MNRM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mnrm assertion failed");

// next-cycle implication
`define MNRM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mnrm assertion failed");

`endif

// File: hdl/mnrm_pkg.sv
// Types and constants shared by the note region mapper.
package mnrm_pkg;

	localparam int SLOTS_DEF  = 32;
	localparam int BASE_NOTE  = 36;
	localparam int ADDR_MAX_W = 8;

	localparam logic [2:0] KIND_EVENT = 3'd0;
	localparam logic [2:0] KIND_SET   = 3'd1;
	localparam logic [2:0] KIND_BUILD = 3'd2;
	localparam logic [2:0] KIND_START = 3'd3;
	localparam logic [2:0] KIND_STOP  = 3'd4;

	localparam logic RES_TRIGGER = 1'b0;
	localparam logic RES_LEARN   = 1'b1;

	typedef struct packed {
		logic [2:0]  kind;
		logic        note_on;
		logic [6:0]  note;
		logic [6:0]  velocity;
		logic [15:0] sample_pos;
		logic [4:0]  slot;
		logic [7:0]  region;
		logic [5:0]  count;
	} in_word_t;

	typedef struct packed {
		logic        result_kind;
		logic [7:0]  region_res;
		logic [6:0]  velocity_res;
		logic [15:0] sample_pos_res;
		logic [4:0]  slot_res;
		logic [6:0]  note_res;
	} out_word_t;

	typedef struct packed {
		logic                  note_we;
		logic                  region_we;
		logic [ADDR_MAX_W-1:0] waddr;
		logic [ADDR_MAX_W-1:0] raddr;
		logic [6:0]            note;
		logic [7:0]            region;
	} ram_req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FILL,
		ST_EMIT
	} state_t;

endpackage

// File: hdl/mnrm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mnrm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/mnrm_out.sv
// Output register holding one result word until it is taken.
module mnrm_out (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  mnrm_pkg::out_word_t   din,
	output logic                  free,
	output logic                  out_valid,
	input  logic                  out_ready,
	output mnrm_pkg::out_word_t   out_data
);
	import mnrm_pkg::*;

	logic      valid_q;
	out_word_t data_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= din;
		end
	end

endmodule

// File: hdl/mnrm_ctrl.sv
// Sequencer: table scan, default fill, learn mode and register state.
module mnrm_ctrl #(
	parameter int SLOTS = mnrm_pkg::SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  mnrm_pkg::in_word_t   in_data,
	input  logic                 cfg_valid,
	input  logic [8:0]           cfg_data,
	output mnrm_pkg::ram_req_t   ram_req,
	input  logic [6:0]           rd_note,
	input  logic [7:0]           rd_region,
	input  logic                 out_free,
	output logic                 load,
	output mnrm_pkg::out_word_t  pend
);
	import mnrm_pkg::*;

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	state_t         state_q, state_d;
	logic [CW-1:0]  entry_cnt_q;
	logic           armed_q;
	logic [4:0]     learn_slot_q;
	logic [8:0]     num_regions_q;
	logic [CW-1:0]  iss_idx_q;
	logic           chk_vld_q;

	logic [6:0]     note_q;
	logic [6:0]     vel_q;
	logic [15:0]    pos_q;
	logic [7:0]     region_item_q;
	logic [AW-1:0]  fill_idx_q;
	logic [AW-1:0]  fill_last_q;
	logic           fill_item_q;
	out_word_t      pend_q;

	logic           acc;
	logic           iss;
	logic           chk_hit;
	logic           learn_ok;
	logic           slot_ok;
	logic           grow;
	int             cnt_sat;
	logic           fill_end;

	assign in_ready = (state_q == ST_IDLE);
	assign acc      = in_valid && in_ready;
	assign iss      = int'(iss_idx_q) < int'(entry_cnt_q);
	assign chk_hit  = chk_vld_q && (rd_note == note_q) && ({1'b0, rd_region} < num_regions_q);
	assign learn_ok = int'(learn_slot_q) < int'(entry_cnt_q);
	assign slot_ok  = int'(in_data.slot) < SLOTS;
	assign grow     = int'(entry_cnt_q) <= int'(in_data.slot);
	assign cnt_sat  = (int'(in_data.count) > SLOTS) ? SLOTS : int'(in_data.count);
	assign fill_end = (fill_idx_q == fill_last_q);
	assign pend     = pend_q;

	always_comb begin
		state_d       = state_q;
		load          = 1'b0;
		ram_req       = '0;
		ram_req.raddr = ADDR_MAX_W'(iss_idx_q[AW-1:0]);
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					unique case (in_data.kind)
						KIND_EVENT: begin
							if (in_data.note_on && armed_q && learn_ok) begin
								ram_req.note_we = 1'b1;
								ram_req.waddr   = ADDR_MAX_W'(AW'(learn_slot_q));
								ram_req.note    = in_data.note;
								state_d         = ST_EMIT;
							end else if (in_data.note_on && !armed_q && entry_cnt_q != '0) begin
								state_d = ST_SCAN;
							end
						end
						KIND_SET: begin
							if (slot_ok) begin
								state_d = ST_FILL;
							end
						end
						KIND_BUILD: begin
							if (cnt_sat != 0) begin
								state_d = ST_FILL;
							end
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_SCAN: begin
				priority if (chk_hit) begin
					state_d = ST_EMIT;
				end else if (!iss) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_FILL: begin
				ram_req.note_we   = 1'b1;
				ram_req.region_we = 1'b1;
				ram_req.waddr     = ADDR_MAX_W'(fill_idx_q);
				if (fill_item_q && fill_end) begin
					ram_req.note   = note_q;
					ram_req.region = region_item_q;
				end else begin
					ram_req.note   = 7'(BASE_NOTE + int'(fill_idx_q));
					ram_req.region = 8'(fill_idx_q);
				end
				if (fill_end) begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			entry_cnt_q   <= '0;
			armed_q       <= 1'b0;
			learn_slot_q  <= '0;
			num_regions_q <= '0;
			iss_idx_q     <= '0;
			chk_vld_q     <= 1'b0;
		end else begin
			state_q   <= state_d;
			chk_vld_q <= (state_q == ST_SCAN) && iss && (state_d == ST_SCAN);
			if (cfg_valid) begin
				num_regions_q <= cfg_data;
			end
			if (state_q == ST_SCAN && iss) begin
				iss_idx_q <= iss_idx_q + CW'(1);
			end
			if (acc) begin
				unique case (in_data.kind)
					KIND_EVENT: begin
						if (in_data.note_on) begin
							armed_q   <= 1'b0;
							iss_idx_q <= '0;
						end
					end
					KIND_SET: begin
						if (slot_ok && grow) begin
							entry_cnt_q <= CW'(int'(in_data.slot) + 1);
						end
					end
					KIND_BUILD: begin
						entry_cnt_q <= CW'(cnt_sat);
					end
					KIND_START: begin
						armed_q      <= 1'b1;
						learn_slot_q <= in_data.slot;
					end
					KIND_STOP: begin
						armed_q <= 1'b0;
					end
					default: begin
						armed_q <= armed_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			note_q        <= in_data.note;
			vel_q         <= in_data.velocity;
			pos_q         <= in_data.sample_pos;
			region_item_q <= in_data.region;
			pend_q        <= '{RES_LEARN, 8'd0, 7'd0, 16'd0, learn_slot_q, in_data.note};
			if (in_data.kind == KIND_SET) begin
				fill_idx_q  <= grow ? AW'(entry_cnt_q) : AW'(in_data.slot);
				fill_last_q <= AW'(in_data.slot);
				fill_item_q <= 1'b1;
			end else begin
				fill_idx_q  <= '0;
				fill_last_q <= AW'(cnt_sat - 1);
				fill_item_q <= 1'b0;
			end
		end else if (state_q == ST_FILL) begin
			fill_idx_q <= fill_idx_q + AW'(1);
		end
		if (state_q == ST_SCAN && chk_hit) begin
			pend_q <= '{RES_TRIGGER, rd_region, vel_q, pos_q, 5'd0, 7'd0};
		end
	end

endmodule

// File: hdl/midi_note_region_mapper.sv
// Top level of the MIDI note to region mapper.
//
//  channel | signals                        | word
//  in      | in_valid / in_ready / in_data  | in_word_t: event, mapping or learn command
//  out     | out_valid / out_ready / out_data | out_word_t: trigger or learn done
//  cfg     | cfg_valid / cfg_ready / cfg_data | num_regions, 9 bits
//
// One word at a time. A note-on outside learn mode walks the table through the
// note and region RAMs at one entry a cycle, pipelined on the RAM read, and
// stops at the first entry that matches and emits its trigger. Set mapping and
// build defaults write one entry a cycle. The table needs no clearing after
// reset; a full output register stalls only the word that has a result.
module midi_note_region_mapper #(
	parameter int SLOTS = mnrm_pkg::SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  mnrm_pkg::in_word_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output mnrm_pkg::out_word_t  out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [8:0]           cfg_data
);
	import mnrm_pkg::*;

	`include "midi_note_region_mapper_macros.svh"

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	ram_req_t  ram_req;
	logic [6:0] rd_note;
	logic [7:0] rd_region;
	logic      out_free;
	logic      load;
	out_word_t pend;

	assign cfg_ready = 1'b1;

	mnrm_ctrl #(.SLOTS(SLOTS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.ram_req   (ram_req),
		.rd_note   (rd_note),
		.rd_region (rd_region),
		.out_free  (out_free),
		.load      (load),
		.pend      (pend)
	);

	mnrm_ram #(.WIDTH(7), .DEPTH(SLOTS)) u_note_ram (
		.clk   (clk),
		.we    (ram_req.note_we),
		.waddr (ram_req.waddr[AW-1:0]),
		.wdata (ram_req.note),
		.raddr (ram_req.raddr[AW-1:0]),
		.rdata (rd_note)
	);

	mnrm_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_region_ram (
		.clk   (clk),
		.we    (ram_req.region_we),
		.waddr (ram_req.waddr[AW-1:0]),
		.wdata (ram_req.region),
		.raddr (ram_req.raddr[AW-1:0]),
		.rdata (rd_region)
	);

	mnrm_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.din       (pend),
		.free      (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	`MNRM_ASSERT_NOW(a_learn_clean, out_valid && out_data.result_kind == RES_LEARN, out_data.region_res == 8'd0 && out_data.velocity_res == 7'd0 && out_data.sample_pos_res == 16'd0)
	`MNRM_ASSERT_NOW(a_trig_clean, out_valid && out_data.result_kind == RES_TRIGGER, out_data.slot_res == 5'd0 && out_data.note_res == 7'd0)
	`MNRM_ASSERT_NEXT(a_set_busy, in_valid && in_ready && in_data.kind == KIND_SET && int'(in_data.slot) < SLOTS, !in_ready)

endmodule
